[rtl/sps_pkg.sv]
// Package for the stepper position sequencer: command codes, register
// indexes, state and result structures, and the coil phase lookup.
// No dependencies.
`timescale 1ns / 1ps

package sps_pkg;

   localparam logic signed [15:0] ROUNDTRIP_STEPS = 16'sd20480;
   localparam logic [7:0]         PHASE_PATTERN   = 8'h33;

   typedef enum logic [1:0] {
      MODE_TICK         = 2'd0,
      MODE_SET_TARGET   = 2'd1,
      MODE_SET_POSITION = 2'd2,
      MODE_SHIFT        = 2'd3
   } mode_type;

   localparam logic [1:0] CSR_CALLBACK_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_NOTIFY_ENABLE     = 2'd1;
   localparam logic [1:0] CSR_REVERSE_DIRECTION = 2'd2;

   typedef struct packed {
      logic [14:0] callback_interval;
      logic        notify_enable;
      logic        reverse_direction;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         phase_index;
      logic [15:0]        step_counter;
      logic signed [15:0] position;
      logic signed [15:0] target;
      logic               running;
      logic [3:0]         coil_drive;
   } state_type;

   typedef struct packed {
      logic [3:0]         coils;
      logic               running;
      logic signed [15:0] position;
      logic signed [15:0] target;
      logic               notify;
      logic signed [15:0] notify_position;
   } result_type;

   // Two coils on at a time: window of the doubled pattern, shifted by phase.
   function automatic logic [3:0] phase_coils(input logic [1:0] shift);
      logic [11:0] wide;
      begin
         wide = {4'd0, PHASE_PATTERN} << shift;
         phase_coils = wide[7:4];
      end
   endfunction

endpackage

[rtl/stepper_position_sequencer.sv]
// Top level of the stepper position sequencer: handshakes, configuration
// registers, motor state and the result register.
// Depends on sps_pkg and sps_step_unit.
`timescale 1ns / 1ps

//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+---------------------------------
//  req_      | in        | req_valid/req_ready | mode, value
//  rsp_      | out       | rsp_valid/rsp_ready | coils, running, position, target,
//            |           |                     | notify, notify_position
//  csr_      | in        | csr_write_enable    | csr_index, csr_write_data
//
// Every command yields one result transaction: it is held in the input register,
// then in the result register. Throughput is one transaction per cycle while
// the result side does not stall, set by the single state update per cycle.
// Reset is synchronous and active high; it clears the motor state, the valid
// flags and the configuration to its defaults. A stall on the result side
// holds the result register and backs up into the input register, and only
// then drops req_ready.

module stepper_position_sequencer (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_value,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_coils,
   output logic               rsp_running,
   output logic signed [15:0] rsp_position,
   output logic signed [15:0] rsp_target,
   output logic               rsp_notify,
   output logic signed [15:0] rsp_notify_position,

   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_write_data
);

   sps_pkg::cfg_type    cfg_ff;
   sps_pkg::cfg_type    cfg_in;
   sps_pkg::state_type  state_ff;
   sps_pkg::state_type  state_in;
   sps_pkg::result_type result_ff;
   sps_pkg::result_type result_in;

   logic               in_valid_ff;
   logic [1:0]         in_mode_ff;
   logic signed [15:0] in_value_ff;
   logic               out_valid_ff;
   logic               advance;

   // Move the held command into the result register when that slot is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   sps_step_unit u_step (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .mode       (in_mode_ff),
      .value      (in_value_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // Register writes; an index beyond the list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            sps_pkg::CSR_CALLBACK_INTERVAL: cfg_in.callback_interval = csr_write_data;
            sps_pkg::CSR_NOTIFY_ENABLE:     cfg_in.notify_enable     = csr_write_data[0];
            sps_pkg::CSR_REVERSE_DIRECTION: cfg_in.reverse_direction = csr_write_data[0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.callback_interval <= 15'd204;
         cfg_ff.notify_enable     <= 1'b0;
         cfg_ff.reverse_direction <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Control: valid flags and motor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: capture on acceptance, hold while stalled.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff  <= req_mode;
         in_value_ff <= req_value;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_coils           = result_ff.coils;
   assign rsp_running         = result_ff.running;
   assign rsp_position        = result_ff.position;
   assign rsp_target          = result_ff.target;
   assign rsp_notify          = result_ff.notify;
   assign rsp_notify_position = result_ff.notify_position;

endmodule

[rtl/sps_step_unit.sv]
// Next-state and result logic for one command of the stepper sequencer.
// Depends on sps_pkg.
`timescale 1ns / 1ps

module sps_step_unit (
   input  sps_pkg::cfg_type    cfg,
   input  sps_pkg::state_type  state_cur,
   input  logic [1:0]          mode,
   input  logic signed [15:0]  value,
   output sps_pkg::state_type  state_next,
   output sps_pkg::result_type result
);

   sps_pkg::mode_type  mode_code;
   logic [1:0]         phase_shift;
   logic signed [15:0] pos_inc;
   logic signed [15:0] pos_sum;
   logic               fire;

   always_comb begin
      mode_code   = sps_pkg::mode_type'(mode);
      phase_shift = cfg.reverse_direction ? (2'd3 - state_cur.phase_index)
                                          : state_cur.phase_index;
      pos_inc     = state_cur.position + 16'sd1;
      pos_sum     = state_cur.position + value;
      fire        = 1'b0;
      state_next  = state_cur;

      case (mode_code)
         sps_pkg::MODE_TICK: begin
            if (state_cur.running) begin
               if (state_cur.position == state_cur.target) begin
                  state_next.running    = 1'b0;
                  state_next.coil_drive = 4'd0;
               end else begin
                  state_next.coil_drive  = sps_pkg::phase_coils(phase_shift);
                  state_next.phase_index = state_cur.phase_index + 2'd1;
                  if (state_cur.step_counter >= {1'b0, cfg.callback_interval}) begin
                     state_next.step_counter = 16'd0;
                     fire = cfg.notify_enable;
                  end else begin
                     state_next.step_counter = state_cur.step_counter + 16'd1;
                  end
                  state_next.position = (pos_inc >= sps_pkg::ROUNDTRIP_STEPS)
                                        ? 16'sd0 : pos_inc;
               end
            end
         end
         sps_pkg::MODE_SET_TARGET: begin
            state_next.target  = value;
            state_next.running = 1'b1;
         end
         sps_pkg::MODE_SET_POSITION: begin
            state_next.position = value;
         end
         sps_pkg::MODE_SHIFT: begin
            if (pos_sum > state_cur.target && state_cur.position <= state_cur.target) begin
               state_next.target = pos_sum;
            end
            state_next.position = pos_sum;
         end
         default: begin
            state_next = state_cur;
         end
      endcase

      result.coils           = state_next.coil_drive;
      result.running         = state_next.running;
      result.position        = state_next.position;
      result.target          = state_next.target;
      result.notify          = fire;
      result.notify_position = fire ? state_cur.position : 16'sd0;
   end

endmodule

[dv/stepper_position_sequencer_test.sv]
// Self-checking testbench for stepper_position_sequencer: a directed opening, then
// random move sequences under several register settings, with bursty input and stalls.
// Depends on sps_pkg and the RTL top level, which in turn needs sps_step_unit.
`timescale 1ns / 1ps

module stepper_position_sequencer_test;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_REPORTS  = 10;
   localparam int HOLD_CYCLES  = 80;
   localparam int HOLD_TRIGGER = 500;

   // Mirrors the motor state and the registers, predicts one result per
   // command and checks the results in order.
   class stepper_scoreboard;
      sps_pkg::cfg_type    settings;
      logic [1:0]          phase;
      logic [15:0]         steps_since_notify;
      logic signed [15:0]  position;
      logic signed [15:0]  target;
      logic                running;
      logic [3:0]          coils;
      sps_pkg::result_type expected_motion[$];
      int                  mismatches;
      int                  commands_noted;

      function new();
         settings           = '0;
         settings.callback_interval = 15'd204;
         phase              = '0;
         steps_since_notify = '0;
         position           = '0;
         target             = '0;
         running            = 1'b0;
         coils              = '0;
         mismatches         = 0;
         commands_noted     = 0;
      endfunction

      function void write_register(logic [1:0] index, logic [14:0] data);
         case (index)
            sps_pkg::CSR_CALLBACK_INTERVAL: settings.callback_interval = data;
            sps_pkg::CSR_NOTIFY_ENABLE:     settings.notify_enable     = data[0];
            sps_pkg::CSR_REVERSE_DIRECTION: settings.reverse_direction = data[0];
            default: ;
         endcase
      endfunction

      // Advance the mirrored state by one command and queue the result it gives.
      function void note_command(sps_pkg::mode_type mode, logic signed [15:0] value);
         sps_pkg::result_type motion;
         logic signed [15:0]  moved;
         logic [1:0]          slot;
         motion = '0;
         case (mode)
            sps_pkg::MODE_TICK: begin
               if (running) begin
                  if (position == target) begin
                     running = 1'b0;
                     coils   = 4'h0;
                  end else begin
                     slot = settings.reverse_direction ? 2'd3 - phase : phase;
                     case (slot)
                        2'd0:    coils = 4'h3;
                        2'd1:    coils = 4'h6;
                        2'd2:    coils = 4'hC;
                        default: coils = 4'h9;
                     endcase
                     phase = phase + 2'd1;
                     if (steps_since_notify >= {1'b0, settings.callback_interval}) begin
                        steps_since_notify = '0;
                        if (settings.notify_enable) begin
                           motion.notify          = 1'b1;
                           motion.notify_position = position;
                        end
                     end else begin
                        steps_since_notify = steps_since_notify + 16'd1;
                     end
                     // 32767 rolls over to -32768, which is below the roundtrip count
                     position = position + 16'sd1;
                     if (position >= sps_pkg::ROUNDTRIP_STEPS)
                        position = '0;
                  end
               end
            end
            sps_pkg::MODE_SET_TARGET: begin
               target  = value;
               running = 1'b1;
            end
            sps_pkg::MODE_SET_POSITION: position = value;
            default: begin
               moved = position + value;
               // a shift that passes the target drags the target along
               if (moved > target && position <= target)
                  target = moved;
               position = moved;
            end
         endcase
         motion.coils    = coils;
         motion.running  = running;
         motion.position = position;
         motion.target   = target;
         expected_motion.push_back(motion);
         commands_noted++;
      endfunction

      function void report(string what, sps_pkg::result_type want,
                           sps_pkg::result_type seen);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%s at %0t: coils %h/%h running %b/%b position %0d/%0d target %0d/%0d",
                     what, $time, want.coils, seen.coils, want.running, seen.running,
                     want.position, seen.position, want.target, seen.target,
                     " notify %b/%b notify_position %0d/%0d (expected/actual)",
                     want.notify, seen.notify, want.notify_position, seen.notify_position);
      endfunction

      function void check_motion(sps_pkg::result_type seen);
         sps_pkg::result_type want;
         if (expected_motion.size() == 0) begin
            report("unexpected result", '0, seen);
         end else begin
            want = expected_motion.pop_front();
            if (seen.coils !== want.coils || seen.running !== want.running ||
                seen.position !== want.position || seen.target !== want.target ||
                seen.notify !== want.notify ||
                seen.notify_position !== want.notify_position)
               report("result mismatch", want, seen);
         end
      endfunction

      function int pending();
         return expected_motion.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_mode;
   logic signed [15:0] req_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [3:0]         rsp_coils;
   logic               rsp_running;
   logic signed [15:0] rsp_position;
   logic signed [15:0] rsp_target;
   logic               rsp_notify;
   logic signed [15:0] rsp_notify_position;
   logic               csr_write_enable;
   logic [1:0]         csr_index;
   logic [14:0]        csr_write_data;

   stepper_scoreboard motion_board;
   int                burst_left;
   int                cycle_count;
   bit                hold_done;

   stepper_position_sequencer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_coils           (rsp_coils),
      .rsp_running         (rsp_running),
      .rsp_position        (rsp_position),
      .rsp_target          (rsp_target),
      .rsp_notify          (rsp_notify),
      .rsp_notify_position (rsp_notify_position),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // 10 ns clock: low half then high half.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one command from the falling edge and hold it until the block takes it;
   // then close the burst with a random gap when it has run out.
   task automatic offer_command(sps_pkg::mode_type mode, logic signed [15:0] value);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      motion_board.note_command(mode, value);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         req_mode  <= 2'($urandom);
         req_value <= 16'($urandom);
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   // Drop valid and wait until every queued result has been taken.
   task automatic drain_motion();
      @(negedge clock);
      req_valid <= 1'b0;
      while (motion_board.pending() != 0) @(posedge clock);
   endtask

   // Write all three registers on consecutive cycles once the block is idle;
   // unused upper data bits on the flag registers carry junk.
   task automatic program_registers(logic [14:0] interval, logic notify_on,
                                    logic reversed);
      drain_motion();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= sps_pkg::CSR_CALLBACK_INTERVAL;
      csr_write_data   <= interval;
      motion_board.write_register(sps_pkg::CSR_CALLBACK_INTERVAL, interval);
      @(negedge clock);
      csr_index      <= sps_pkg::CSR_NOTIFY_ENABLE;
      csr_write_data <= {14'($urandom), notify_on};
      motion_board.write_register(sps_pkg::CSR_NOTIFY_ENABLE, {14'd0, notify_on});
      @(negedge clock);
      csr_index      <= sps_pkg::CSR_REVERSE_DIRECTION;
      csr_write_data <= {14'($urandom), reversed};
      motion_board.write_register(sps_pkg::CSR_REVERSE_DIRECTION, {14'd0, reversed});
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= 15'($urandom);
   endtask

   // Mostly complete moves (place, aim a few steps ahead, tick until stopped)
   // with the odd shift or retarget mixed in; the rest is random noise.
   task automatic random_moves(int count);
      int                 issued;
      int                 distance;
      int                 ticks;
      logic signed [15:0] start;
      logic signed [15:0] aim;
      issued = 0;
      while (issued < count) begin
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 4))
               0:       start = 16'(int'($urandom_range(0, 32)) - 16);
               1:       start = 16'($urandom_range(20470, 20479));
               2:       start = 16'($urandom_range(20480, 32767));
               3:       start = 16'sh7FFF;
               default: start = 16'($urandom);
            endcase
            distance = $urandom_range(0, 12);
            aim = start;
            for (int j = 0; j < distance; j++) begin
               aim = aim + 16'sd1;
               if (aim >= sps_pkg::ROUNDTRIP_STEPS)
                  aim = '0;
            end
            offer_command(sps_pkg::MODE_SET_POSITION, start);
            offer_command(sps_pkg::MODE_SET_TARGET, aim);
            ticks = distance + 1 + $urandom_range(0, 2);
            for (int j = 0; j < ticks; j++) begin
               case ($urandom_range(0, 19))
                  0:       offer_command(sps_pkg::MODE_SHIFT,
                                         16'(int'($urandom_range(0, 8)) - 4));
                  1:       offer_command(sps_pkg::MODE_SET_TARGET,
                                         aim + 16'(int'($urandom_range(0, 4)) - 2));
                  default: offer_command(sps_pkg::MODE_TICK, 16'($urandom));
               endcase
            end
            issued += ticks + 2;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               offer_command(sps_pkg::mode_type'(2'($urandom)), 16'($urandom));
               issued++;
            end
         end
      end
   endtask

   // Take results at the rising edge and hand them to the scoreboard.
   always @(posedge clock) begin
      sps_pkg::result_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.coils           = rsp_coils;
         seen.running         = rsp_running;
         seen.position        = rsp_position;
         seen.target          = rsp_target;
         seen.notify          = rsp_notify;
         seen.notify_position = rsp_notify_position;
         motion_board.check_motion(seen);
      end
   end

   // Receiver: stretches of steady, mostly-on, patchy or sparse acceptance, plus one long
   // hold-off partway through so the block backs up and drops req_ready.
   initial begin
      int style;
      int stretch;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      wait (reset === 1'b0);
      forever begin
         style   = $urandom_range(0, 3);
         stretch = $urandom_range(10, 60);
         repeat (stretch) begin
            @(negedge clock);
            case (style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
         if (!hold_done && motion_board.commands_noted >= HOLD_TRIGGER) begin
            hold_done = 1'b1;
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
      end
   end

   // Watchdog: give up well beyond the slowest legal run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("stepper_position_sequencer regression: fail");
      $finish;
   end

   initial begin
      motion_board     = new();
      burst_left       = 1;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = sps_pkg::MODE_TICK;
      req_value        = '0;
      csr_write_enable = 1'b0;
      csr_index        = sps_pkg::CSR_CALLBACK_INTERVAL;
      csr_write_data   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening: short notify interval, forward phase order.
      program_registers(15'd2, 1'b1, 1'b0);
      offer_command(sps_pkg::MODE_TICK, -16'sd32768);          // stopped: nothing moves
      offer_command(sps_pkg::MODE_SET_POSITION, 16'sh7FFF);
      offer_command(sps_pkg::MODE_SET_TARGET, -16'sd32766);    // starts the motor
      offer_command(sps_pkg::MODE_TICK, '0);                   // rolls over to -32768
      offer_command(sps_pkg::MODE_TICK, '0);
      offer_command(sps_pkg::MODE_TICK, '0);                   // third step fires notify
      offer_command(sps_pkg::MODE_TICK, '0);                   // on target: stop, coils off
      offer_command(sps_pkg::MODE_TICK, 16'sh7FFF);            // stopped again
      offer_command(sps_pkg::MODE_SET_POSITION, 16'sd20478);
      offer_command(sps_pkg::MODE_SET_TARGET, 16'sd2);
      offer_command(sps_pkg::MODE_SET_TARGET, 16'sd3);         // retarget while running
      repeat (5) offer_command(sps_pkg::MODE_TICK, '0);        // wraps at the roundtrip count
      offer_command(sps_pkg::MODE_TICK, '0);
      offer_command(sps_pkg::MODE_SHIFT, -16'sd32768);
      offer_command(sps_pkg::MODE_SHIFT, 16'sd5);              // stays below the target
      offer_command(sps_pkg::MODE_SHIFT, 16'sd10);             // still below the target
      offer_command(sps_pkg::MODE_SHIFT, 16'sh7FFF);           // crosses: target follows
      offer_command(sps_pkg::MODE_SET_POSITION, 16'sd25000);   // beyond the roundtrip count
      offer_command(sps_pkg::MODE_SET_TARGET, 16'sd1);
      offer_command(sps_pkg::MODE_TICK, '0);                   // snaps back to zero

      // Random phases over a spread of settings, extremes included; the last one
      // lowers the interval below a running count.
      for (int setting = 0; setting < 6; setting++) begin
         case (setting)
            0:       program_registers(15'd0, 1'b1, 1'b1);
            1:       program_registers(15'h7FFF, 1'b1, 1'b0);
            2:       program_registers(15'($urandom_range(0, 15)), 1'b1, 1'($urandom));
            3:       program_registers(15'd5, 1'b0, 1'b1);
            4:       program_registers(15'd40, 1'b1, 1'b0);
            default: program_registers(15'd1, 1'b1, 1'b1);
         endcase
         random_moves(200);
      end

      drain_motion();
      repeat (4) @(posedge clock);
      if (motion_board.mismatches == 0 && motion_board.pending() == 0)
         $display("stepper_position_sequencer regression: pass");
      else
         $display("stepper_position_sequencer regression: fail");
      $finish;
   end

endmodule
